// ===== design/gcd_of_differences_unit_macros.svh =====
// Assertion macros shared by the gcd of differences unit.
`ifndef GCD_OF_DIFFERENCES_UNIT_MACROS_SVH
`define GCD_OF_DIFFERENCES_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define GCDDU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd of differences unit: assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define GCDDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd of differences unit: assertion failed");

`else

`define GCDDU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GCDDU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/gcddu_pkg.sv =====
// Package with the types, constants and microprogram of the gcd of differences unit.
`default_nettype none

package gcddu_pkg;

    localparam int SAMPLE_BITS        = 32;
    localparam int GCD_OUT_BITS       = 32;
    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int UPC_BITS           = 3;

    typedef logic [UPC_BITS-1:0] upc_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_COPY_B,
        OP_SHIFT_BOTH,
        OP_SHIFT_A,
        OP_SHIFT_B,
        OP_SUB,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_A_ZERO,
        CND_B_ZERO,
        CND_BOTH_EVEN,
        CND_A_EVEN,
        CND_B_EVEN
    } cond_t;

    // Microprogram addresses.
    localparam upc_t UPC_TEST_A    = 3'd0;
    localparam upc_t UPC_TEST_B    = 3'd1;
    localparam upc_t UPC_COMMON    = 3'd2;
    localparam upc_t UPC_STRIP_A   = 3'd3;
    localparam upc_t UPC_TEST_DIFF = 3'd4;
    localparam upc_t UPC_STRIP_B   = 3'd5;
    localparam upc_t UPC_FINISH    = 3'd6;

    // One control word: a condition picks one of two operation/next-address pairs.
    typedef struct packed {
        cond_t cond;
        op_t   op_true;
        upc_t  next_true;
        op_t   op_false;
        upc_t  next_false;
    } uword_t;

    typedef struct packed {
        logic busy;
        op_t  op;
    } seq_ctrl_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_even;
        logic b_even;
    } dp_flags_t;

    // Binary gcd of a and b, leaving the odd part in a and the common power of two in k when both are nonzero.
    function automatic uword_t ucode_rom(input upc_t upc);
        uword_t w;
        unique case (upc)
            UPC_TEST_A:    w = '{CND_A_ZERO,    OP_COPY_B,     UPC_FINISH,
                                 OP_NOP,        UPC_TEST_B};
            UPC_TEST_B:    w = '{CND_B_ZERO,    OP_NOP,        UPC_FINISH,
                                 OP_NOP,        UPC_COMMON};
            UPC_COMMON:    w = '{CND_BOTH_EVEN, OP_SHIFT_BOTH, UPC_COMMON,
                                 OP_NOP,        UPC_STRIP_A};
            UPC_STRIP_A:   w = '{CND_A_EVEN,    OP_SHIFT_A,    UPC_STRIP_A,
                                 OP_NOP,        UPC_TEST_DIFF};
            UPC_TEST_DIFF: w = '{CND_B_ZERO,    OP_NOP,        UPC_FINISH,
                                 OP_NOP,        UPC_STRIP_B};
            UPC_STRIP_B:   w = '{CND_B_EVEN,    OP_SHIFT_B,    UPC_STRIP_B,
                                 OP_SUB,        UPC_TEST_DIFF};
            default:       w = '{CND_ALWAYS,    OP_FINISH,     UPC_TEST_A,
                                 OP_FINISH,     UPC_TEST_A};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/gcddu_sample_if.sv =====
// Interface for the input channel: one signed sample and its last mark per item.
`default_nettype none

interface gcddu_sample_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [gcddu_pkg::SAMPLE_BITS-1:0]   sample_value;
    logic                                       last_item;

    modport source (output valid, output sample_value, output last_item, input ready);
    modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface

`default_nettype wire

// ===== design/gcddu_result_if.sv =====
// Interface for the output channel: one gcd result and its found flag per item.
`default_nettype none

interface gcddu_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [gcddu_pkg::GCD_OUT_BITS-1:0]   gcd_value;
    logic                                 found;

    modport source (output valid, output gcd_value, output found, input ready);
    modport sink   (input valid, input gcd_value, input found, output ready);
endinterface

`default_nettype wire

// ===== design/gcd_of_differences_unit.sv =====
// Top level of the gcd of differences unit: handshakes, set state and result register.
`default_nettype none

`include "gcd_of_differences_unit_macros.svh"

// The unit reads a set of signed integers, one item per sample, the final item of
// each set carrying last_item. For every set it returns one item holding the
// greatest common divisor of all differences between the values, that is the
// largest modulus under which they are all congruent, with found set when at
// least two distinct values were seen; when every value is equal (or the set has
// a single item) gcd_value is 0 and found is 0. Samples are taken as
// VALUE_BITS-bit two's complement numbers (truncated or sign extended), the gcd
// is worked out at that width and gcd_value carries its low 32 bits. The first
// item of a set is only stored as the reference value. Every later item runs a
// short binary gcd microprogram over one shared shift/subtract datapath, folding
// the absolute difference from the reference into the running gcd: a load, zero
// tests of both operands, a shift per common factor of two, a shift per stripped
// factor of two, and a zero test and a subtraction per reduction step. Items are
// taken one at a time; a finished result waits in the output register while the
// next item of the following set is accepted.
module gcd_of_differences_unit #(
    parameter int VALUE_BITS = gcddu_pkg::DEFAULT_VALUE_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    gcddu_sample_if.sink   samples,
    gcddu_result_if.source results
);
    import gcddu_pkg::*;

    logic [VALUE_BITS-1:0]   value_ext;
    logic [VALUE_BITS-1:0]   v_minus_r;
    logic [VALUE_BITS-1:0]   r_minus_v;
    logic                    v_lt_r;
    logic [VALUE_BITS-1:0]   abs_diff;
    logic [VALUE_BITS-1:0]   dp_result;
    logic [GCD_OUT_BITS-1:0] gcd_low;

    seq_ctrl_t ctrl;
    dp_flags_t flags;

    logic accept;
    logic start;
    logic done;
    logic emit;

    // Control state.
    logic have_ref_reg;
    logic have_ref_next;
    logic last_pending_reg;
    logic last_pending_next;
    logic emit_req_reg;
    logic emit_req_next;
    logic out_valid_reg;
    logic out_valid_next;

    // Payload.
    logic [VALUE_BITS-1:0]   ref_reg;
    logic [VALUE_BITS-1:0]   ref_next;
    logic [VALUE_BITS-1:0]   gcd_reg;
    logic [VALUE_BITS-1:0]   gcd_next;
    logic [GCD_OUT_BITS-1:0] out_gcd_reg;
    logic [GCD_OUT_BITS-1:0] out_gcd_next;
    logic                    out_found_reg;
    logic                    out_found_next;

    // Bring the 32-bit sample to the working width.
    generate
        if (VALUE_BITS <= SAMPLE_BITS)
        begin : g_narrow
            assign value_ext = samples.sample_value[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign value_ext = {{(VALUE_BITS-SAMPLE_BITS){samples.sample_value[SAMPLE_BITS-1]}},
                                samples.sample_value};
        end
    endgenerate

    // The result field keeps the low bits of the gcd, zero extended when narrower.
    generate
        if (VALUE_BITS >= GCD_OUT_BITS)
        begin : g_out_trunc
            assign gcd_low = gcd_reg[GCD_OUT_BITS-1:0];
        end
        else
        begin : g_out_ext
            assign gcd_low = {{(GCD_OUT_BITS-VALUE_BITS){1'b0}}, gcd_reg};
        end
    endgenerate

    // The true difference of two VALUE_BITS-bit numbers always fits in VALUE_BITS
    // bits unsigned, so both wrapped subtractions are exact once the sign is known.
    assign v_minus_r = value_ext - ref_reg;
    assign r_minus_v = ref_reg - value_ext;
    assign v_lt_r    = $signed(value_ext) < $signed(ref_reg);
    assign abs_diff  = v_lt_r ? r_minus_v : v_minus_r;

    assign samples.ready = !ctrl.busy && !emit_req_reg;
    assign accept        = samples.valid && samples.ready;
    assign start         = accept && have_ref_reg;
    assign done          = (ctrl.op == OP_FINISH);
    assign emit          = emit_req_reg && (!out_valid_reg || results.ready);

    gcddu_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl)
    );

    gcddu_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .load_a (gcd_reg),
        .load_b (abs_diff),
        .ctrl   (ctrl),
        .flags  (flags),
        .result (dp_result)
    );

    always_comb
    begin
        have_ref_next     = have_ref_reg;
        last_pending_next = last_pending_reg;
        emit_req_next     = emit_req_reg;
        out_valid_next    = out_valid_reg;
        ref_next          = ref_reg;
        gcd_next          = gcd_reg;
        out_gcd_next      = out_gcd_reg;
        out_found_next    = out_found_reg;

        if (accept)
        begin
            if (!have_ref_reg)
            begin
                // First item of a set: it becomes the reference, no gcd work.
                ref_next      = value_ext;
                gcd_next      = '0;
                have_ref_next = 1'b1;
                emit_req_next = samples.last_item;
            end
            else
            begin
                last_pending_next = samples.last_item;
            end
        end

        if (done)
        begin
            gcd_next = dp_result;
            if (last_pending_reg)
            begin
                emit_req_next = 1'b1;
            end
        end

        if (emit)
        begin
            // Hand the set's result to the output register and start a new set.
            out_valid_next = 1'b1;
            out_gcd_next   = gcd_low;
            out_found_next = (gcd_reg != '0);
            emit_req_next  = 1'b0;
            have_ref_next  = 1'b0;
            gcd_next       = '0;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_ref_reg     <= 1'b0;
            last_pending_reg <= 1'b0;
            emit_req_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            have_ref_reg     <= have_ref_next;
            last_pending_reg <= last_pending_next;
            emit_req_reg     <= emit_req_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg       <= ref_next;
        gcd_reg       <= gcd_next;
        out_gcd_reg   <= out_gcd_next;
        out_found_reg <= out_found_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.gcd_value = out_gcd_reg;
    assign results.found     = out_found_reg;

    `GCDDU_ASSERT_NEXT(a_start_runs, clk, rst_n, start, ctrl.busy)
    `GCDDU_ASSERT_NEXT(a_finish_idles, clk, rst_n, done, !ctrl.busy)
    `GCDDU_ASSERT_IMPLIES(a_no_emit_while_busy, clk, rst_n, emit_req_reg, !ctrl.busy)
    `GCDDU_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, emit,
                       out_valid_reg && !emit_req_reg && !have_ref_reg)

endmodule

`default_nettype wire

// ===== design/gcddu_sequencer.sv =====
// Microcode sequencer: step counter, control word table and conditional jumps.
`default_nettype none

module gcddu_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gcddu_pkg::dp_flags_t flags,
    output gcddu_pkg::seq_ctrl_t ctrl
);
    import gcddu_pkg::*;

    logic   busy_reg;
    logic   busy_next;
    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uword;
    logic   cond_true;
    op_t    op_sel;

    assign uword = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (uword.cond)
            CND_ALWAYS:    cond_true = 1'b1;
            CND_A_ZERO:    cond_true = flags.a_zero;
            CND_B_ZERO:    cond_true = flags.b_zero;
            CND_BOTH_EVEN: cond_true = flags.a_even && flags.b_even;
            CND_A_EVEN:    cond_true = flags.a_even;
            CND_B_EVEN:    cond_true = flags.b_even;
            default:       cond_true = 1'b1;
        endcase
    end

    assign op_sel = cond_true ? uword.op_true : uword.op_false;

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (busy_reg)
        begin
            upc_next = cond_true ? uword.next_true : uword.next_false;
            if (op_sel == OP_FINISH)
            begin
                busy_next = 1'b0;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            upc_next  = UPC_TEST_A;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= UPC_TEST_A;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    always_comb
    begin
        ctrl.busy = busy_reg;
        ctrl.op   = busy_reg ? op_sel : OP_NOP;
    end

endmodule

`default_nettype wire

// ===== design/gcddu_datapath.sv =====
// Binary gcd datapath: two operand registers, a shift count and two subtractors.
`default_nettype none

`include "gcd_of_differences_unit_macros.svh"

module gcddu_datapath #(
    parameter int VALUE_BITS = gcddu_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] load_a,
    input  logic [VALUE_BITS-1:0] load_b,
    input  gcddu_pkg::seq_ctrl_t  ctrl,
    output gcddu_pkg::dp_flags_t  flags,
    output logic [VALUE_BITS-1:0] result
);
    import gcddu_pkg::*;

    localparam int K_BITS = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] a_reg;
    logic [VALUE_BITS-1:0] a_next;
    logic [VALUE_BITS-1:0] b_reg;
    logic [VALUE_BITS-1:0] b_next;
    logic [K_BITS-1:0]     k_reg;
    logic [K_BITS-1:0]     k_next;
    logic [VALUE_BITS-1:0] a_minus_b;
    logic [VALUE_BITS-1:0] b_minus_a;
    logic                  a_gt_b;

    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;
    assign a_gt_b    = a_reg > b_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (start)
        begin
            a_next = load_a;
            b_next = load_b;
            k_next = '0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_COPY_B:
                begin
                    a_next = b_reg;
                end
                OP_SHIFT_BOTH:
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + K_BITS'(1);
                end
                OP_SHIFT_A:
                begin
                    a_next = a_reg >> 1;
                end
                OP_SHIFT_B:
                begin
                    b_next = b_reg >> 1;
                end
                OP_SUB:
                begin
                    // Keep the smaller odd value in a, the even difference in b.
                    if (a_gt_b)
                    begin
                        a_next = b_reg;
                        b_next = a_minus_b;
                    end
                    else
                    begin
                        b_next = b_minus_a;
                    end
                end
                default:
                begin
                    a_next = a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    always_comb
    begin
        flags.a_zero = (a_reg == '0);
        flags.b_zero = (b_reg == '0);
        flags.a_even = !a_reg[0];
        flags.b_even = !b_reg[0];
    end

    assign result = a_reg << k_reg;

    `GCDDU_ASSERT_IMPLIES(a_sub_on_odd, clk, rst_n, ctrl.op == OP_SUB, a_reg[0] && b_reg[0])
    `GCDDU_ASSERT_IMPLIES(a_shift_a_even, clk, rst_n, ctrl.op == OP_SHIFT_A, !a_reg[0])
    `GCDDU_ASSERT_IMPLIES(a_shift_both_even, clk, rst_n, ctrl.op == OP_SHIFT_BOTH,
                          !a_reg[0] && !b_reg[0])

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the gcd of differences unit: directed and random sets.
`default_nettype none

module tb;
    import gcddu_pkg::*;

    localparam int VALUE_BITS = DEFAULT_VALUE_BITS;

    // Worst case for one item in the block, with some margin for the output register.
    localparam int SETTLE_CYCLES = 6 * VALUE_BITS + 60;
    localparam int ITEM_TARGET = 1350;
    localparam int HOLDOFF_AFTER = 400;
    localparam int HOLDOFF_CYCLES = 600;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        logic                   last;
        int unsigned            gap;
        bit                     drain_first;
    } sample_item_t;

    typedef struct {
        logic [GCD_OUT_BITS-1:0] gcd_value;
        logic                    found;
    } gcd_result_t;

    logic clk = 1'b0;
    logic rst_n;

    gcddu_sample_if sample_ch ();
    gcddu_result_if result_ch ();

    gcd_of_differences_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    always #4 clk = ~clk;

    // Items still to be offered, and the results the current sets will produce.
    sample_item_t samples_to_send[$];
    gcd_result_t  gcd_results_due[$];

    // Our own view of the set in progress.
    logic signed [63:0] set_anchor;
    logic [63:0]        set_gcd;
    bit                 set_open;

    int  fault_count    = 0;
    int  accepted_count = 0;
    int  results_seen   = 0;
    bit  holdoff        = 1'b0;
    bit  steady_stretch = 1'b0;
    bit  drain_next     = 1'b0;

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 64'd0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Folds one accepted item into the set; the item marked last yields a result.
    function automatic void fold_sample(logic [SAMPLE_BITS-1:0] raw, logic last_mark);
        logic signed [63:0] v;
        logic [63:0]        delta;
        gcd_result_t        res;
        // Sign extend the sample, then reinterpret it at the block's value width.
        v = 64'(signed'(raw));
        v = (v <<< (64 - VALUE_BITS)) >>> (64 - VALUE_BITS);
        if (!set_open)
        begin
            set_anchor = v;
            set_gcd    = 64'd0;
            set_open   = 1'b1;
        end
        else
        begin
            delta   = (v >= set_anchor) ? 64'(v - set_anchor) : 64'(set_anchor - v);
            set_gcd = euclid_gcd(set_gcd, delta);
        end
        if (last_mark)
        begin
            res.gcd_value = set_gcd[GCD_OUT_BITS-1:0];
            res.found     = (set_gcd != 64'd0);
            gcd_results_due = {gcd_results_due, res};
            set_anchor = 64'sd0;
            set_gcd    = 64'd0;
            set_open   = 1'b0;
        end
    endfunction

    function automatic void add_sample(logic [SAMPLE_BITS-1:0] value, bit last_mark);
        sample_item_t it;
        it.value       = value;
        it.last        = last_mark;
        it.gap         = steady_stretch ? 0 : $urandom_range(0, 9);
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        samples_to_send = {samples_to_send, it};
    endfunction

    // Sender: takes items from the queue, waits out each item's gap, then offers it.
    sample_item_t current;
    bit           holding = 1'b0;
    int unsigned  gap_left = 0;
    bit           offer_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.sample_value <= '0;
            sample_ch.last_item    <= 1'b0;
            holding  = 1'b0;
            gap_left = 0;
            set_open = 1'b0;
            set_anchor = 64'sd0;
            set_gcd  = 64'd0;
        end
        else
        begin
            offer_next = 1'b0;
            if (sample_ch.valid && !sample_ch.ready)
            begin
                offer_next = 1'b1;
            end
            else
            begin
                if (sample_ch.valid && sample_ch.ready)
                begin
                    fold_sample(sample_ch.sample_value, sample_ch.last_item);
                    accepted_count++;
                    holding = 1'b0;
                end
                if (!holding && samples_to_send.size() != 0)
                begin
                    current  = samples_to_send.pop_front();
                    holding  = 1'b1;
                    gap_left = current.gap;
                end
                if (holding)
                begin
                    // Some items hold back until every outstanding result has come.
                    if (current.drain_first && gcd_results_due.size() != 0)
                        offer_next = 1'b0;
                    else if (gap_left > 0)
                        gap_left--;
                    else
                        offer_next = 1'b1;
                end
            end
            sample_ch.valid <= offer_next;
            if (offer_next)
            begin
                sample_ch.sample_value <= current.value;
                sample_ch.last_item    <= current.last;
            end
        end
    end

    // Receiver: checks each result against the oldest prediction and stalls at random.
    int unsigned stall_left = 0;
    gcd_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (gcd_results_due.size() == 0)
                begin
                    $error("unexpected result: gcd_value %0d, found %0b",
                           result_ch.gcd_value, result_ch.found);
                    fault_count++;
                end
                else
                begin
                    want = gcd_results_due.pop_front();
                    if (result_ch.gcd_value !== want.gcd_value)
                    begin
                        $error("gcd_value: expected %0d, actual %0d",
                               want.gcd_value, result_ch.gcd_value);
                        fault_count++;
                    end
                    if (result_ch.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b",
                               want.found, result_ch.found);
                        fault_count++;
                    end
                end
                results_seen++;
                // Every so often a run of results is taken without any stall.
                stall_left = ((results_seen % 64) < 8) ? 0 : $urandom_range(0, 9);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            result_ch.ready <= (stall_left == 0) && !holdoff;
        end
    end

    // Long back-pressure stretch: the block fills up and must stall its input.
    initial
    begin
        wait (accepted_count >= HOLDOFF_AFTER);
        @(posedge clk);
        holdoff <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("gcd_of_differences_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic [SAMPLE_BITS-1:0] base;
        logic [SAMPLE_BITS-1:0] step;
        logic [SAMPLE_BITS-1:0] v;
        int                     kind;
        int                     set_len;
        bit                     first_set;

        rst_n = 1'b0;

        // Directed sets. A set of one item, and all-equal sets, give no gcd.
        add_sample(32'd5, 1'b1);
        add_sample(32'h8000_0000, 1'b1);
        add_sample(32'd7, 1'b0);
        add_sample(32'd7, 1'b0);
        add_sample(32'd7, 1'b1);
        // Widest possible difference, the two ends of the signed range.
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h7fff_ffff, 1'b1);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'd0, 1'b1);
        add_sample(32'd12, 1'b0);
        add_sample(-32'sd6, 1'b0);
        add_sample(32'd30, 1'b1);
        // Equal values first, a distinct one only at the end of the set.
        add_sample(32'd4, 1'b0);
        add_sample(32'd4, 1'b0);
        add_sample(32'd10, 1'b1);
        add_sample(32'd1, 1'b0);
        add_sample(32'd2, 1'b1);
        add_sample(32'd0, 1'b0);
        add_sample(32'd1024, 1'b0);
        add_sample(-32'sd4096, 1'b1);
        add_sample(32'hffff_ffff, 1'b0);
        add_sample(32'd0, 1'b1);

        // Random sets, mostly of values that share a chosen modulus.
        first_set = 1'b1;
        while (samples_to_send.size() < ITEM_TARGET)
        begin
            steady_stretch = ($urandom_range(0, 7) == 0);
            drain_next     = first_set || ($urandom_range(0, 39) == 0);
            first_set      = 1'b0;
            kind    = $urandom_range(0, 9);
            set_len = (kind == 9) ? 1 : $urandom_range(2, 8);
            base    = $urandom;
            case ($urandom_range(0, 3))
                0:       step = $urandom_range(1, 16);
                1:       step = 32'd1 << $urandom_range(0, 31);
                2:       step = $urandom;
                default: step = 32'($urandom_range(1, 1000)) << $urandom_range(0, 12);
            endcase
            for (int i = 0; i < set_len; i++)
            begin
                if (kind <= 5)
                    v = base + step * 32'($urandom_range(0, 20) - 10);
                else if (kind == 6)
                    v = base;
                else if (kind == 8)
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = 32'd0;
                        3:       v = 32'hffff_ffff;
                        4:       v = 32'd1;
                        default: v = $urandom;
                    endcase
                end
                else
                    v = $urandom;
                add_sample(v, i == set_len - 1);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (samples_to_send.size() != 0 || holding || sample_ch.valid
               || gcd_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("gcd_of_differences_unit: match");
        else
            $display("gcd_of_differences_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
